// File: sv/xsr_pkg.sv
// ----------------------------------------------------------------------------
// xsr_pkg
// Shared types, command codes and the xorshift step for the ranged random core
// ----------------------------------------------------------------------------
package xsr_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned CntW  = $clog2(WordW);

	localparam logic [1:0] CMD_SEED    = 2'd0;
	localparam logic [1:0] CMD_BOUNDED = 2'd1;
	localparam logic [1:0] CMD_RANGE   = 2'd2;

	localparam logic [WordW-1:0] SEED_FALLBACK = 32'd1;

	typedef struct packed {
		logic load;
		logic step;
		logic emit;
	} xsr_cmd_t;

	typedef struct packed {
		logic is_draw;
		logic skip;
	} xsr_status_t;

	function automatic logic [WordW-1:0] xorshift_next(input logic [WordW-1:0] x);
		logic [WordW-1:0] t;
		t = x ^ (x << 13);
		t = t ^ (t >> 17);
		t = t ^ (t << 5);
		return t;
	endfunction

endpackage

// File: sv/xsr_ctrl.sv
// ----------------------------------------------------------------------------
// xsr_ctrl
// Controller: accepts transactions, sequences the remainder steps and hands
// results to the output register
// ----------------------------------------------------------------------------
module xsr_ctrl import xsr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  xsr_status_t status,
	output xsr_cmd_t    ctl
);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_DIVIDE = 3'b010,
		S_EMIT   = 3'b100
	} state_t;

	state_t            state_q;
	state_t            state_d;
	logic [CntW-1:0]   cnt_q;
	logic              out_valid_q;
	logic              accept;
	logic              last_step;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign last_step = (cnt_q == CntW'(WordW - 1));
	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		ctl.load = 1'b0;
		ctl.step = 1'b0;
		ctl.emit = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					ctl.load = 1'b1;
					if (status.is_draw) begin
						state_d = status.skip ? S_EMIT : S_DIVIDE;
					end
				end
			end
			S_DIVIDE: begin
				ctl.step = 1'b1;
				if (last_step) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (!out_valid_q || out_ready) begin
					ctl.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.step) begin
				cnt_q <= cnt_q + CntW'(1);
			end else begin
				cnt_q <= '0;
			end
			if (ctl.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// emit never overwrites a result still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> (!out_valid_q || out_ready))
		else $error("xsr_ctrl: result overwritten");

	// a draw that needs the remainder goes to the divide sequence
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && status.is_draw && !status.skip) |=> (state_q == S_DIVIDE && cnt_q == '0))
		else $error("xsr_ctrl: divide not started");

	// the divide sequence ends after a full word of steps
	assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.step && last_step) |=> (state_q == S_EMIT))
		else $error("xsr_ctrl: divide length wrong");

	// emit is always followed by a valid result
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |=> (out_valid_q && state_q == S_IDLE))
		else $error("xsr_ctrl: result not presented");

endmodule

// File: sv/xsr_datapath.sv
// ----------------------------------------------------------------------------
// xsr_datapath
// Datapath: generator state, range set-up, radix-2 remainder unit and the
// result register
// ----------------------------------------------------------------------------
module xsr_datapath import xsr_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [1:0]              cmd,
	input  logic signed [WordW-1:0] value_a,
	input  logic signed [WordW-1:0] value_b,
	input  xsr_cmd_t                ctl,
	output xsr_status_t             status,
	output logic signed [WordW-1:0] draw
);

	logic [WordW-1:0] gen_q;
	logic [WordW-1:0] dividend_q;
	logic [WordW-1:0] divisor_q;
	logic [WordW-1:0] rem_q;
	logic [WordW-1:0] lo_q;
	logic             raw_q;
	logic [WordW-1:0] draw_q;

	logic [WordW-1:0] a_u;
	logic [WordW-1:0] b_u;
	logic [WordW-1:0] gen_next;
	logic             bounded_ok;
	logic             swap;
	logic [WordW-1:0] lo_sel;
	logic [WordW-1:0] hi_sel;
	logic [WordW-1:0] span;
	logic [WordW:0]   partial;
	logic [WordW:0]   diff;

	assign a_u        = value_a;
	assign b_u        = value_b;
	assign gen_next   = xorshift_next(gen_q);
	assign bounded_ok = !a_u[WordW-1] && (a_u != '0);
	assign swap       = (value_b < value_a);
	assign lo_sel     = swap ? b_u : a_u;
	assign hi_sel     = swap ? a_u : b_u;
	assign span       = hi_sel - lo_sel + WordW'(1);

	assign status.is_draw = (cmd == CMD_BOUNDED) || (cmd == CMD_RANGE);
	assign status.skip    = (cmd == CMD_BOUNDED) ? !bounded_ok : (span == '0);

	assign partial = {rem_q, dividend_q[WordW-1]};
	assign diff    = partial - {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= SEED_FALLBACK;
		end else if (ctl.load) begin
			case (cmd)
				CMD_SEED: begin
					gen_q <= (a_u != '0) ? a_u : SEED_FALLBACK;
				end
				CMD_BOUNDED: begin
					if (bounded_ok) begin
						gen_q <= gen_next;
					end
				end
				CMD_RANGE: begin
					gen_q <= gen_next;
				end
				default: begin
					gen_q <= gen_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q <= '0;
			if (cmd == CMD_BOUNDED) begin
				lo_q       <= '0;
				divisor_q  <= a_u + WordW'(1);
				raw_q      <= !bounded_ok;
				dividend_q <= bounded_ok ? gen_next : '0;
			end else begin
				lo_q       <= lo_sel;
				divisor_q  <= span;
				raw_q      <= (span == '0);
				dividend_q <= gen_next;
			end
		end else if (ctl.step) begin
			dividend_q <= {dividend_q[WordW-2:0], 1'b0};
			rem_q      <= diff[WordW] ? partial[WordW-1:0] : diff[WordW-1:0];
		end
		if (ctl.emit) begin
			draw_q <= lo_q + (raw_q ? dividend_q : rem_q);
		end
	end

	assign draw = draw_q;

endmodule

// File: sv/xorshift32_ranged_random_core.sv
// ----------------------------------------------------------------------------
// xorshift32_ranged_random_core
// Xorshift32 generator with bounded and two-limit integer range draws
// ----------------------------------------------------------------------------
// an accepted draw needing a remainder runs S_DIVIDE at one bit per cycle,
//   then S_EMIT; one needing none (max at most zero, full-word range) goes
//   straight to S_EMIT, which waits while a result is unread; no request
//   is taken outside S_IDLE, so draws do not overlap; a seed gives no result
// reset: generator word set to 1, controller idle, no result pending
module xorshift32_ranged_random_core import xsr_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              cmd,
	input  logic signed [WordW-1:0] value_a,
	input  logic signed [WordW-1:0] value_b,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [WordW-1:0] draw
);

	xsr_cmd_t    ctl;
	xsr_status_t status;

	xsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.ctl       (ctl)
	);

	xsr_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.value_a (value_a),
		.value_b (value_b),
		.ctl     (ctl),
		.status  (status),
		.draw    (draw)
	);

endmodule
